// ===== rtl/core/stm_pkg.sv =====
// ----------------------------------------------------------------------------
// stm_pkg
// shared types and codes for the sparse triplet merge-subtract block
// ----------------------------------------------------------------------------
package stm_pkg;

    localparam int ACTION_W    = 2;
    localparam int FIELD_W     = 16;
    localparam int VALUE_W     = 32;
    localparam int OUT_VALUE_W = 33;

    localparam logic [ACTION_W-1:0] ACT_LOAD_A = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_B = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RUN    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]       kind;
        logic [FIELD_W-1:0]        row;
        logic [FIELD_W-1:0]        col;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } qhead_t;

endpackage

// ===== rtl/core/stm_ram.sv =====
// ----------------------------------------------------------------------------
// stm_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module stm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/stm_front.sv =====
// ----------------------------------------------------------------------------
// stm_front
// accepts input transfers, drops unused codes, queues commands for the back end
// ----------------------------------------------------------------------------
module stm_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [stm_pkg::ACTION_W-1:0] action,
    input  logic [stm_pkg::FIELD_W-1:0]  row,
    input  logic [stm_pkg::FIELD_W-1:0]  col,
    input  logic signed [stm_pkg::VALUE_W-1:0] value,
    output stm_pkg::qhead_t           q_head,
    input  logic                      q_pop
);

    stm_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    fill_reg;
    logic [1:0]    fill_next;
    logic          push;
    stm_pkg::cmd_t in_cmd;

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall && (action != stm_pkg::ACT_NONE);

    always_comb
    begin
        in_cmd.kind  = action;
        in_cmd.row   = row;
        in_cmd.col   = col;
        in_cmd.value = value;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !q_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assign q_head.valid = (fill_reg != 2'd0);
    assign q_head.cmd   = slot_reg[rd_ptr_reg];

endmodule

// ===== rtl/core/stm_back.sv =====
// ----------------------------------------------------------------------------
// stm_back
// stores loaded triplets and walks both lists to emit the merged difference
// ----------------------------------------------------------------------------
module stm_back #(
    parameter int DEPTH      = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stm_pkg::qhead_t       q_head,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [stm_pkg::FIELD_W-1:0] out_row,
    output logic [stm_pkg::FIELD_W-1:0] out_col,
    output logic signed [stm_pkg::OUT_VALUE_W-1:0] out_value,
    output logic                  last
);

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int CB     = COORD_BITS;
    localparam int VW     = stm_pkg::VALUE_W;
    localparam int FW     = stm_pkg::FIELD_W;
    localparam int OW     = stm_pkg::OUT_VALUE_W;
    localparam int WORD_W = 2 * CB + VW;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic          state_reg;
    logic          state_next;
    logic [CW-1:0] ca_reg;
    logic [CW-1:0] ca_next;
    logic [CW-1:0] cb_reg;
    logic [CW-1:0] cb_next;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] i_next;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] j_next;

    logic              we_a;
    logic              we_b;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] rdata_a;
    logic [WORD_W-1:0] rdata_b;
    logic [CB-1:0]     ld_row;
    logic [CB-1:0]     ld_col;

    logic              a_ok;
    logic              b_ok;
    logic              take_a;
    logic              take_b;
    logic [2*CB-1:0]   key_a;
    logic [2*CB-1:0]   key_b;
    logic [CB-1:0]     sel_row;
    logic [CB-1:0]     sel_col;
    logic [FW+CB-1:0]  sel_row_ext;
    logic [FW+CB-1:0]  sel_col_ext;
    logic [CB+FW-1:0]  row_ext;
    logic [CB+FW-1:0]  col_ext;
    logic signed [OW-1:0] opnd_a;
    logic signed [OW-1:0] opnd_b;
    logic signed [OW-1:0] diff;

    logic              out_free;
    logic              step;
    logic              last_c;
    logic              out_valid_reg;
    logic [FW-1:0]     out_row_reg;
    logic [FW-1:0]     out_col_reg;
    logic signed [OW-1:0] out_value_reg;
    logic              last_reg;

    // load data, coordinates cut to the stored width
    assign row_ext = {{CB{1'b0}}, q_head.cmd.row};
    assign col_ext = {{CB{1'b0}}, q_head.cmd.col};
    assign ld_row  = row_ext[CB-1:0];
    assign ld_col  = col_ext[CB-1:0];
    assign wdata   = {ld_row, ld_col, q_head.cmd.value};

    stm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (ca_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (i_next[AW-1:0]),
        .rdata (rdata_a)
    );

    stm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (cb_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (j_next[AW-1:0]),
        .rdata (rdata_b)
    );

    // merge decision on the current heads
    assign key_a = rdata_a[WORD_W-1:VW];
    assign key_b = rdata_b[WORD_W-1:VW];
    assign a_ok  = (i_reg < ca_reg);
    assign b_ok  = (j_reg < cb_reg);

    always_comb
    begin
        take_a = 1'b0;
        take_b = 1'b0;
        if (a_ok && b_ok)
        begin
            if (key_a == key_b)
            begin
                take_a = 1'b1;
                take_b = 1'b1;
            end
            else if (key_a < key_b)
            begin
                take_a = 1'b1;
            end
            else
            begin
                take_b = 1'b1;
            end
        end
        else if (a_ok)
        begin
            take_a = 1'b1;
        end
        else
        begin
            take_b = 1'b1;
        end
    end

    assign sel_row = take_a ? rdata_a[WORD_W-1 -: CB] : rdata_b[WORD_W-1 -: CB];
    assign sel_col = take_a ? rdata_a[VW +: CB] : rdata_b[VW +: CB];
    assign opnd_a  = take_a ? {rdata_a[VW-1], rdata_a[VW-1:0]} : {OW{1'b0}};
    assign opnd_b  = take_b ? {rdata_b[VW-1], rdata_b[VW-1:0]} : {OW{1'b0}};
    assign diff    = opnd_a - opnd_b;

    assign sel_row_ext = {{FW{1'b0}}, sel_row};
    assign sel_col_ext = {{FW{1'b0}}, sel_col};

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        q_pop      = 1'b0;
        we_a       = 1'b0;
        we_b       = 1'b0;
        step       = 1'b0;
        last_c     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop = 1'b1;
                    case (q_head.cmd.kind)
                        stm_pkg::ACT_LOAD_A:
                        begin
                            if (ca_reg < CW'(DEPTH))
                            begin
                                we_a    = 1'b1;
                                ca_next = ca_reg + CW'(1);
                            end
                        end
                        stm_pkg::ACT_LOAD_B:
                        begin
                            if (cb_reg < CW'(DEPTH))
                            begin
                                we_b    = 1'b1;
                                cb_next = cb_reg + CW'(1);
                            end
                        end
                        stm_pkg::ACT_RUN:
                        begin
                            i_next = '0;
                            j_next = '0;
                            if ((ca_reg != '0) || (cb_reg != '0))
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    step   = 1'b1;
                    i_next = i_reg + CW'(take_a);
                    j_next = j_reg + CW'(take_b);
                    if (!(i_next < ca_reg) && !(j_next < cb_reg))
                    begin
                        last_c     = 1'b1;
                        ca_next    = '0;
                        cb_next    = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ca_reg        <= '0;
            cb_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ca_reg        <= ca_next;
            cb_reg        <= cb_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= step || (out_valid_reg && out_stall);
        end
    end

    // result register, one transfer per cycle while the sink keeps up
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_row_reg   <= sel_row_ext[FW-1:0];
            out_col_reg   <= sel_col_ext[FW-1:0];
            out_value_reg <= diff;
            last_reg      <= last_c;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/core/sparse_triplet_merge_subtract.sv =====
// ----------------------------------------------------------------------------
// sparse_triplet_merge_subtract
// loads two row-major triplet lists and emits their merged difference a - b
// ----------------------------------------------------------------------------
// load: one transfer per cycle outside a run, queued, then written into its list ram
// run: after the run leaves the two-entry queue, the list rams are read, then
//   one result per cycle while the sink keeps up (max(count_a, count_b) to
//   count_a + count_b results), paced by the merge walk over the two list rams
// reset: both counts and the queue clear at once, list contents stay undefined
// ----------------------------------------------------------------------------
module sparse_triplet_merge_subtract #(
    parameter int DEPTH      = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [stm_pkg::ACTION_W-1:0]           action,
    input  logic [stm_pkg::FIELD_W-1:0]            row,
    input  logic [stm_pkg::FIELD_W-1:0]            col,
    input  logic signed [stm_pkg::VALUE_W-1:0]     value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [stm_pkg::FIELD_W-1:0]            out_row,
    output logic [stm_pkg::FIELD_W-1:0]            out_col,
    output logic signed [stm_pkg::OUT_VALUE_W-1:0] out_value,
    output logic                                   last
);

    stm_pkg::qhead_t q_head;
    logic            q_pop;

    stm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .row      (row),
        .col      (col),
        .value    (value),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    stm_back #(
        .DEPTH      (DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .last      (last)
    );

endmodule

// ===== rtl/core/stm_checker.sv =====
// ----------------------------------------------------------------------------
// stm_checker
// port-level checks for the sparse triplet merge-subtract block
// ----------------------------------------------------------------------------
module stm_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic [stm_pkg::FIELD_W-1:0]            out_row,
    input logic [stm_pkg::FIELD_W-1:0]            out_col,
    input logic signed [stm_pkg::OUT_VALUE_W-1:0] out_value,
    input logic                                   last
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_value) && $stable(out_row)
            && $stable(out_col) && $stable(last))
        else $error("stalled result changed");

    // a - b of two 32-bit values never reaches the most negative 33-bit code
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_value != {1'b1, {(stm_pkg::OUT_VALUE_W - 1){1'b0}}})
        else $error("result value out of range");

    // coordinates come from stored entries of COORD_BITS bits
    a_coord_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (COORD_BITS < stm_pkg::FIELD_W)
            |-> ((out_row >> COORD_BITS) == '0) && ((out_col >> COORD_BITS) == '0))
        else $error("result coordinate wider than stored");

endmodule

bind sparse_triplet_merge_subtract stm_checker #(
    .COORD_BITS (COORD_BITS)
) u_stm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .last      (last)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for sparse_triplet_merge_subtract
// loads sorted and unsorted triplet lists into a and b, runs merges and checks
// every merged difference entry against an in-bench model of the merge walk,
// with random idling on both sides, a long output hold and drain pauses
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH         = 32;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEM_TARGET   = 430;
    localparam int REPORT_LIMIT  = 10;
    localparam int FW            = stm_pkg::FIELD_W;
    localparam int VW            = stm_pkg::VALUE_W;
    localparam int OVW           = stm_pkg::OUT_VALUE_W;
    localparam int AW            = stm_pkg::ACTION_W;

    typedef struct packed {
        logic [FW-1:0]        row;
        logic [FW-1:0]        col;
        logic signed [VW-1:0] value;
    } triplet_t;

    typedef struct packed {
        logic [FW-1:0]         row;
        logic [FW-1:0]         col;
        logic signed [OVW-1:0] value;
        logic                  last;
    } diff_entry_t;

    typedef enum int {SEQ_NOISE, SEQ_SMALL, SEQ_WIDE, SEQ_LARGE} seq_kind_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [AW-1:0]         action;
    logic [FW-1:0]         row;
    logic [FW-1:0]         col;
    logic signed [VW-1:0]  value;
    logic                  out_valid;
    logic                  out_stall;
    logic [FW-1:0]         out_row;
    logic [FW-1:0]         out_col;
    logic signed [OVW-1:0] out_value;
    logic                  last;

    triplet_t    stored_a [DEPTH];
    triplet_t    stored_b [DEPTH];
    int          fill_a = 0;
    int          fill_b = 0;
    diff_entry_t pending_diffs [$];
    diff_entry_t observed;
    diff_entry_t wanted;
    int          mismatches = 0;
    int          effective_items = 0;
    bit          quiet = 1'b0;
    int          holds_requested = 0;
    int          holds_served = 0;

    sparse_triplet_merge_subtract #(
        .DEPTH      (DEPTH),
        .COORD_BITS (FW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL sparse_triplet_merge_subtract");
        $finish;
    end

    // merge walk over both stored lists, row first then column
    task automatic predict_merge();
        diff_entry_t           run_q [$];
        diff_entry_t           e;
        int                    ia;
        int                    ib;
        logic [2*FW-1:0]       key_a;
        logic [2*FW-1:0]       key_b;
        logic signed [OVW-1:0] va;
        logic signed [OVW-1:0] vb;
        ia = 0;
        ib = 0;
        key_a = '0;
        key_b = '0;
        va = '0;
        vb = '0;
        while (ia < fill_a || ib < fill_b)
        begin
            if (ia < fill_a)
            begin
                key_a = {stored_a[ia].row, stored_a[ia].col};
                va = $signed(stored_a[ia].value);
            end
            if (ib < fill_b)
            begin
                key_b = {stored_b[ib].row, stored_b[ib].col};
                vb = $signed(stored_b[ib].value);
            end
            e.last = 1'b0;
            if (ia < fill_a && (ib >= fill_b || key_a < key_b))
            begin
                e.row = stored_a[ia].row;
                e.col = stored_a[ia].col;
                e.value = va;
                ia++;
            end
            else if (ib < fill_b && (ia >= fill_a || key_b < key_a))
            begin
                e.row = stored_b[ib].row;
                e.col = stored_b[ib].col;
                e.value = -vb;
                ib++;
            end
            else
            begin
                e.row = stored_a[ia].row;
                e.col = stored_a[ia].col;
                e.value = va - vb;
                ia++;
                ib++;
            end
            run_q.push_back(e);
        end
        if (run_q.size() != 0)
            run_q[run_q.size()-1].last = 1'b1;
        foreach (run_q[x])
            pending_diffs.push_back(run_q[x]);
        fill_a = 0;
        fill_b = 0;
    endtask

    task automatic apply_transfer(input logic [AW-1:0] act, input triplet_t t);
        case (act)
            stm_pkg::ACT_LOAD_A:
                if (fill_a < DEPTH)
                begin
                    stored_a[fill_a] = t;
                    fill_a++;
                    effective_items++;
                end
            stm_pkg::ACT_LOAD_B:
                if (fill_b < DEPTH)
                begin
                    stored_b[fill_b] = t;
                    fill_b++;
                    effective_items++;
                end
            stm_pkg::ACT_RUN:
            begin
                predict_merge();
                effective_items++;
            end
            default:
                ;
        endcase
    endtask

    task automatic send_transfer(input logic [AW-1:0] act, input logic [FW-1:0] r,
                                 input logic [FW-1:0] c,
                                 input logic signed [VW-1:0] v);
        triplet_t t;
        t.row = r;
        t.col = c;
        t.value = v;
        if (!quiet && $urandom_range(0, 99) < 16)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        action <= act;
        row <= r;
        col <= c;
        value <= v;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        apply_transfer(act, t);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_diffs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [VW-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2*FW-1:0] pick_key(input int span_bits);
        logic [31:0]   k;
        logic [FW-1:0] mask;
        k = $urandom;
        mask = FW'((32'd1 << span_bits) - 1);
        return {k[31:16] & mask, k[15:0] & mask};
    endfunction

    task automatic send_sequence(input seq_kind_t kind);
        logic [2*FW-1:0] keys [$];
        logic [2*FW-1:0] k;
        triplet_t        list_a_q [$];
        triplet_t        list_b_q [$];
        triplet_t        t;
        int              n;
        int              span;
        int              owner;
        bit              fresh;
        if (kind == SEQ_NOISE)
        begin
            // unsorted loads with duplicates, stray codes
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                k = pick_key($urandom_range(0, 1) ? 3 : FW);
                send_transfer(AW'($urandom_range(stm_pkg::ACT_LOAD_A, stm_pkg::ACT_NONE)),
                              k[31:16], k[15:0], pick_value());
            end
            if ($urandom_range(0, 1))
                send_transfer(stm_pkg::ACT_RUN, FW'($urandom), FW'($urandom), $urandom);
            return;
        end
        case (kind)
            SEQ_SMALL:
            begin
                n = $urandom_range(0, 10);
                span = 3;
            end
            SEQ_WIDE:
            begin
                n = $urandom_range(0, 10);
                span = FW;
            end
            default:
            begin
                n = $urandom_range(20, 48);
                span = 4;
            end
        endcase
        while (keys.size() < n)
        begin
            k = pick_key(span);
            fresh = 1'b1;
            foreach (keys[x])
                if (keys[x] == k)
                    fresh = 1'b0;
            if (fresh)
                keys.push_back(k);
        end
        keys.sort();
        foreach (keys[x])
        begin
            owner = $urandom_range(0, 2);
            t.row = keys[x][31:16];
            t.col = keys[x][15:0];
            t.value = pick_value();
            if (owner != 1)
                list_a_q.push_back(t);
            if (owner != 0)
            begin
                // b entry, at the same position as in a when both own it, sometimes equal values
                if (!(owner == 2 && $urandom_range(0, 3) == 0))
                    t.value = pick_value();
                list_b_q.push_back(t);
            end
        end
        while (list_a_q.size() != 0 || list_b_q.size() != 0)
        begin
            if ($urandom_range(0, 29) == 0)
                send_transfer(stm_pkg::ACT_NONE, FW'($urandom), FW'($urandom), $urandom);
            if (list_b_q.size() == 0 || (list_a_q.size() != 0 && $urandom_range(0, 1)))
            begin
                t = list_a_q.pop_front();
                send_transfer(stm_pkg::ACT_LOAD_A, t.row, t.col, t.value);
            end
            else
            begin
                t = list_b_q.pop_front();
                send_transfer(stm_pkg::ACT_LOAD_B, t.row, t.col, t.value);
            end
        end
        send_transfer(stm_pkg::ACT_RUN, FW'($urandom), FW'($urandom), $urandom);
    endtask

    task automatic test_empty_run();
        send_transfer(stm_pkg::ACT_RUN, '0, '0, '0);
        wait_drained();
    endtask

    task automatic test_value_extremes();
        send_transfer(stm_pkg::ACT_LOAD_A, '0, '0, 32'sh8000_0000);
        send_transfer(stm_pkg::ACT_LOAD_A, 16'hffff, 16'hffff, 32'sh7fff_ffff);
        send_transfer(stm_pkg::ACT_LOAD_B, '0, '0, 32'sh7fff_ffff);
        send_transfer(stm_pkg::ACT_LOAD_B, 16'hffff, 16'hffff, 32'sh8000_0000);
        send_transfer(stm_pkg::ACT_RUN, 16'hffff, 16'hffff, 32'sh7fff_ffff);
        wait_drained();
    endtask

    task automatic test_one_sided_entries();
        // equal values kept as zero, b-only negated, a-only passed
        send_transfer(stm_pkg::ACT_LOAD_A, 16'd1, 16'd2, 32'sd5);
        send_transfer(stm_pkg::ACT_LOAD_B, 16'd1, 16'd2, 32'sd5);
        send_transfer(stm_pkg::ACT_LOAD_B, 16'h7fff, 16'hffff, -32'sd9);
        send_transfer(stm_pkg::ACT_LOAD_A, 16'h8000, 16'h0001, '0);
        send_transfer(stm_pkg::ACT_RUN, '0, '0, '0);
        send_transfer(stm_pkg::ACT_LOAD_B, 16'd3, 16'd3, 32'sh8000_0000);
        send_transfer(stm_pkg::ACT_RUN, '0, '0, '0);
        wait_drained();
    endtask

    task automatic test_unsorted_duplicates();
        send_transfer(stm_pkg::ACT_LOAD_A, 16'd5, 16'd0, 32'sd1);
        send_transfer(stm_pkg::ACT_LOAD_A, 16'd2, 16'd0, 32'sd2);
        send_transfer(stm_pkg::ACT_NONE, 16'hffff, 16'hffff, -32'sd1);
        send_transfer(stm_pkg::ACT_LOAD_A, 16'd2, 16'd0, 32'sd3);
        send_transfer(stm_pkg::ACT_LOAD_B, 16'd3, 16'd1, 32'sd4);
        send_transfer(stm_pkg::ACT_LOAD_B, 16'd2, 16'd0, -32'sd6);
        send_transfer(stm_pkg::ACT_RUN, '0, '0, '0);
        wait_drained();
    endtask

    task automatic test_full_lists();
        logic [FW-1:0] c;
        for (int x = 0; x < DEPTH + 2; x++)
        begin
            c = x[0] ? FW'($urandom) : FW'(x);
            send_transfer(stm_pkg::ACT_LOAD_A, FW'(x), c, pick_value());
        end
        for (int x = 0; x < DEPTH + 3; x++)
        begin
            c = x[0] ? FW'($urandom) : FW'(x);
            send_transfer(stm_pkg::ACT_LOAD_B, FW'(x), c, pick_value());
        end
        send_transfer(stm_pkg::ACT_RUN, '0, '0, '0);
        wait_drained();
    endtask

    task automatic test_output_hold();
        quiet = 1'b1;
        holds_requested++;
        repeat (6) send_sequence($urandom_range(0, 1) ? SEQ_SMALL : SEQ_WIDE);
        quiet = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_merges();
        int roll;
        while (effective_items < ITEM_TARGET)
        begin
            quiet = (effective_items >= 250 && effective_items < 330);
            roll = $urandom_range(0, 19);
            if (roll < 2)
                send_sequence(SEQ_NOISE);
            else if (roll < 3)
                send_sequence(SEQ_LARGE);
            else if (roll < 11)
                send_sequence(SEQ_SMALL);
            else
                send_sequence(SEQ_WIDE);
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        quiet = 1'b0;
    endtask

    // output stall: random idling, or a counted hold when one is requested
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_served != holds_requested)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !quiet && $urandom_range(0, 99) < 16;
        end
    end

    task automatic note_mismatch(input string what, input diff_entry_t exp_e,
                                 input diff_entry_t got_e);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $write("mismatch, %s: expected row %h col %h value %0d last %b, ",
                   what, exp_e.row, exp_e.col, $signed(exp_e.value), exp_e.last);
            $display("got row %h col %h value %0d last %b",
                     got_e.row, got_e.col, $signed(got_e.value), got_e.last);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            observed.row = out_row;
            observed.col = out_col;
            observed.value = out_value;
            observed.last = last;
            if (pending_diffs.size() == 0)
                note_mismatch("transfer with nothing pending", '0, observed);
            else
            begin
                wanted = pending_diffs.pop_front();
                if (observed.row !== wanted.row)
                    note_mismatch("out_row", wanted, observed);
                if (observed.col !== wanted.col)
                    note_mismatch("out_col", wanted, observed);
                if (observed.value !== wanted.value)
                    note_mismatch("out_value", wanted, observed);
                if (observed.last !== wanted.last)
                    note_mismatch("last", wanted, observed);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = stm_pkg::ACT_NONE;
        row = '0;
        col = '0;
        value = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_run();
        test_value_extremes();
        test_one_sided_entries();
        test_unsorted_duplicates();
        test_full_lists();
        test_output_hold();
        test_random_merges();

        wait_drained();
        if (mismatches == 0)
            $display("PASS sparse_triplet_merge_subtract");
        else
            $display("FAIL sparse_triplet_merge_subtract");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/stm_pkg.sv
rtl/core/stm_ram.sv
rtl/core/stm_front.sv
rtl/core/stm_back.sv
rtl/core/sparse_triplet_merge_subtract.sv
rtl/core/stm_checker.sv
tb/sv/testbench.sv
